FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define SPMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spmf assertion failed");

// property checked at every edge, reset included
`define SPMF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spmf assertion failed");

`endif

FILE: src/spmf_pkg.sv
// ----------------------------------------------------------------------------
// spmf_pkg
// shared sizes, types and value conversions of the strict priority queue
// ----------------------------------------------------------------------------
package spmf_pkg;

    localparam int PRI_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int IO_W      = 32;
    localparam int PRIO_W    = 3;
    localparam int LVL_W     = $clog2(PRI_LEVELS);
    localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int FILL_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = PRI_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        ST_ADD_OK    = 2'd0,
        ST_ADD_FULL  = 2'd1,
        ST_EXT_OK    = 2'd2,
        ST_EXT_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ADD     = 1'b0,
        REQ_EXTRACT = 1'b1
    } t_req;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // store port command issued by the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_value            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_cmd;

    // per-word decision of the controller
    typedef struct packed {
        t_status status;
        logic    rd;
    } t_ctrl_res;

    // input word to stored width (sign extend or cut)
    function automatic t_value to_store(input logic signed [IO_W-1:0] v);
        return VALUE_WIDTH'(v);
    endfunction

    // stored width back to the 32-bit output (sign extend or cut)
    function automatic logic [IO_W-1:0] to_out(input logic signed [VALUE_WIDTH-1:0] v);
        return IO_W'(v);
    endfunction

endpackage

FILE: src/spmf_store.sv
// ----------------------------------------------------------------------------
// spmf_store
// value memory of all levels, one write and one registered read port
// ----------------------------------------------------------------------------
module spmf_store (
    input  logic              i_clk,
    input  spmf_pkg::t_mem_cmd i_cmd,
    output spmf_pkg::t_value   o_rd_data
);
    import spmf_pkg::*;

    t_value r_mem [MEM_DEPTH];
    t_value r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rd_data <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/spmf_ctrl.sv
// ----------------------------------------------------------------------------
// spmf_ctrl
// per-level pointers and fill counts, top level search, store commands
// ----------------------------------------------------------------------------
module spmf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_req_type,
    input  logic [31:0]               i_value,
    input  logic [2:0]                i_priority_req,
    output spmf_pkg::t_mem_cmd        o_cmd,
    output spmf_pkg::t_ctrl_res       o_res
);
    import spmf_pkg::*;

    logic [PTR_W-1:0]  r_rd_ptr [PRI_LEVELS];
    logic [PTR_W-1:0]  r_wr_ptr [PRI_LEVELS];
    logic [FILL_W-1:0] r_fill   [PRI_LEVELS];
    logic [PTR_W-1:0]  n_rd_ptr [PRI_LEVELS];
    logic [PTR_W-1:0]  n_wr_ptr [PRI_LEVELS];
    logic [FILL_W-1:0] n_fill   [PRI_LEVELS];

    logic             any_busy;
    logic [LVL_W-1:0] top_lvl;
    logic [LVL_W-1:0] add_lvl;
    logic             lvl_ok;
    logic             lvl_full;
    logic             do_add;
    logic             do_ext;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // highest non-empty level, larger index wins
    always_comb begin
        any_busy = 1'b0;
        top_lvl  = '0;
        for (int k = 0; k < PRI_LEVELS; k++) begin
            if (r_fill[k] != '0) begin
                any_busy = 1'b1;
                top_lvl  = LVL_W'(k);
            end
        end
    end

    // add target checks
    assign lvl_ok   = 32'(i_priority_req) < PRI_LEVELS;
    assign add_lvl  = LVL_W'(i_priority_req);
    assign lvl_full = r_fill[add_lvl] == FILL_W'(LEVEL_DEPTH);
    assign do_add   = i_accept && (i_req_type == REQ_ADD) && lvl_ok && !lvl_full;
    assign do_ext   = i_accept && (i_req_type == REQ_EXTRACT) && any_busy;

    // store commands; a read never meets the write of the same word
    always_comb begin
        o_cmd.we    = do_add;
        o_cmd.waddr = ADDR_W'(add_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(r_wr_ptr[add_lvl]);
        o_cmd.wdata = to_store(i_value);
        o_cmd.re    = do_ext;
        o_cmd.raddr = ADDR_W'(top_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(r_rd_ptr[top_lvl]);
    end

    // result code of the word
    always_comb begin
        o_res.rd = do_ext;
        if (i_req_type == REQ_ADD) begin
            o_res.status = (lvl_ok && !lvl_full) ? ST_ADD_OK : ST_ADD_FULL;
        end else begin
            o_res.status = any_busy ? ST_EXT_OK : ST_EXT_EMPTY;
        end
    end

    // pointer and fill update
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        if (do_add) begin
            n_wr_ptr[add_lvl] = next_ptr(r_wr_ptr[add_lvl]);
            n_fill[add_lvl]   = r_fill[add_lvl] + 1'b1;
        end
        if (do_ext) begin
            n_rd_ptr[top_lvl] = next_ptr(r_rd_ptr[top_lvl]);
            n_fill[top_lvl]   = r_fill[top_lvl] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PRI_LEVELS; k++) begin
                r_rd_ptr[k] <= '0;
                r_wr_ptr[k] <= '0;
                r_fill[k]   <= '0;
            end
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

FILE: src/strict_priority_multi_fifo.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// strict priority queue with one fifo per level, stream in and out
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is an add (tuser = 0) or an extract (tuser = 1). An add
//   puts tdata value into the fifo of tdata priority; an extract takes the
//   oldest value of the highest non-empty level. Every input word yields
//   exactly one output word: tuser carries the status, tdata the value
//   (echo for an add, removed value for an extract, all ones when empty).
//   Adds and extracts alike take the same path from input acceptance to
//   output valid: the registered read of the value memory, taken together
//   with the middle stage, and then the output register.
//   Throughput is one word per cycle while the receiver does not stall; the
//   two-register path of middle stage and output register keeps it full.
//   When the receiver stalls, the output word holds and one more word is
//   taken into the middle stage; after that s_axis_tready drops.
//   Reset clears all pointers and fill counts, leaving every level empty;
//   the value memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value [31:0], priority_req [34:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // req_type [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_value [31:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);
    import spmf_pkg::*;

    logic        accept;
    logic        s1_adv;
    t_mem_cmd    mem_cmd;
    t_ctrl_res   ctrl_res;
    t_value      rd_data;

    logic        r_s1_valid;
    t_status     r_s1_status;
    logic        r_s1_rd;
    logic [31:0] r_s1_value;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_value;

    // handshake
    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    spmf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (s_axis_tuser[0]),
        .i_value        (s_axis_tdata[31:0]),
        .i_priority_req (s_axis_tdata[34:32]),
        .o_cmd          (mem_cmd),
        .o_res          (ctrl_res)
    );

    spmf_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    // middle stage, waits for the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= ctrl_res.status;
            r_s1_rd     <= ctrl_res.rd;
            if (ctrl_res.status == ST_EXT_EMPTY) begin
                r_s1_value <= '1;
            end else begin
                r_s1_value <= to_out(to_store(s_axis_tdata[31:0]));
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_status <= r_s1_status;
            r_out_value  <= r_s1_rd ? to_out(rd_data) : r_s1_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: src/spmf_checker.sv
// ----------------------------------------------------------------------------
// spmf_checker
// port level checks of the strict priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import spmf_pkg::*;

    // stalled output word holds
    `SPMF_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // no output word right after reset
    `SPMF_ASSERT_ALWAYS(a_rst_quiet, i_clk, $past(!i_rst_n) |-> !m_axis_tvalid)

    // empty extract always reports all ones
    `SPMF_ASSERT(a_empty_val, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser == ST_EXT_EMPTY) |-> (m_axis_tdata == 32'hFFFF_FFFF))

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
